FILE: src/plist_pkg.sv
// shared types and constants for the positional list engine
package plist_pkg;

	// largest list the cell row is built for, sets the width of cell indexes
	localparam int PL_DEPTH_MAX = 64;
	localparam int PL_IDX_W     = $clog2(PL_DEPTH_MAX);
	localparam int PL_DEPTH_DEF = 16;

	// operation codes of a request word
	typedef enum logic [2:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_POS  = 3'd2,
		OP_DEL_HEAD = 3'd3,
		OP_DEL_TAIL = 3'd4,
		OP_DEL_POS  = 3'd5,
		OP_READ_ALL = 3'd6
	} op_t;

	// status codes of a response word
	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_EMPTY   = 3'd1,
		STAT_INVALID = 3'd2,
		STAT_BOUNDS  = 3'd3,
		STAT_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
		logic        [7:0]  position;
	} req_word_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		status_t            status;
		logic               last;
		logic        [4:0]  length;
	} rsp_word_t;

	// what every cell of the row does this cycle
	typedef enum logic [1:0] {
		CK_HOLD   = 2'd0,
		CK_INSERT = 2'd1,
		CK_DELETE = 2'd2,
		CK_ROTATE = 2'd3
	} cell_kind_t;

	typedef struct packed {
		cell_kind_t          kind;
		logic [PL_IDX_W-1:0] idx;   // edit point
		logic [PL_IDX_W-1:0] tail;  // last occupied cell, for rotation
	} cell_cmd_t;

endpackage

FILE: src/positional_list_engine.sv
// positional list engine top level: control, element count, cell row, response register
//
// Holds an ordered list of up to DEPTH signed 32-bit values in a row of cells.
// Request channel (req_valid/req_ready/req) carries one word per operation:
// insert at head, tail or 1-based position, delete at head, tail or position,
// or read out the whole list. Response channel (rsp_valid/rsp_ready/rsp)
// returns one word per edit, or one word per element for a read-out, with
// last set on the final word of each request.
// An edit is done in the accept cycle: every cell shifts at once, and the
// response is registered, so it shows in the cycle after acceptance. The next
// request can be taken in the following cycle, also while the response is
// being taken. A read-out of n elements rotates the cell row once per word,
// so it produces n words (one word when empty) and blocks new requests
// until the last word has been registered.
// A stalled receiver holds the response register; no new work is started
// and no cell moves until it frees up. Reset empties the list and drops any
// pending response; the cell contents need no clearing.
module positional_list_engine import plist_pkg::*; #(
	parameter int DEPTH = PL_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_READ = 2'b10
	} fsm_t;

	fsm_t               fsm_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rd_left_q;
	logic               rsp_valid_q;
	rsp_word_t          rsp_q;

	logic signed [31:0] cell_q     [DEPTH];
	logic signed [31:0] left_w     [DEPTH];
	logic signed [31:0] right_w    [DEPTH];

	logic               out_free;
	logic               acc;
	cell_cmd_t          cmd;

	logic               full;
	logic               empty;
	logic [8:0]         pos_x;
	logic [8:0]         cnt_x;
	status_t            ed_status;
	cell_kind_t         ed_kind;
	logic [IDX_W-1:0]   ed_idx;
	logic [CNT_W-1:0]   cnt_d;
	logic               go_read;
	logic signed [31:0] ed_val;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (fsm_q == FSM_IDLE) && out_free;
	assign acc       = req_valid && req_ready;

	// decode the request against the current length
	always_comb begin
		full      = (cnt_q >= CNT_W'(DEPTH));
		empty     = (cnt_q == '0);
		pos_x     = {1'b0, req.position};
		cnt_x     = 9'(cnt_q);
		ed_status = STAT_OK;
		ed_kind   = CK_HOLD;
		ed_idx    = '0;
		cnt_d     = cnt_q;
		go_read   = 1'b0;
		case (req.op)
			OP_INS_HEAD, OP_INS_TAIL: begin
				if (full) begin
					ed_status = STAT_FULL;
				end else begin
					ed_kind = CK_INSERT;
					ed_idx  = (req.op == OP_INS_HEAD) ? '0 : IDX_W'(cnt_q);
					cnt_d   = cnt_q + 1'b1;
				end
			end
			OP_INS_POS: begin
				if (req.position == '0) begin
					ed_status = STAT_INVALID;
				end else if (full) begin
					ed_status = STAT_FULL;
				end else if (pos_x > cnt_x + 9'd1) begin
					ed_status = STAT_BOUNDS;
				end else begin
					ed_kind = CK_INSERT;
					ed_idx  = IDX_W'(req.position - 8'd1);
					cnt_d   = cnt_q + 1'b1;
				end
			end
			OP_DEL_HEAD, OP_DEL_TAIL: begin
				if (empty) begin
					ed_status = STAT_EMPTY;
				end else begin
					ed_kind = CK_DELETE;
					ed_idx  = (req.op == OP_DEL_HEAD) ? '0 : IDX_W'(cnt_q - 1'b1);
					cnt_d   = cnt_q - 1'b1;
				end
			end
			OP_DEL_POS: begin
				if (req.position == '0 || empty) begin
					ed_status = STAT_INVALID;
				end else if (pos_x > cnt_x) begin
					ed_status = STAT_BOUNDS;
				end else begin
					ed_kind = CK_DELETE;
					ed_idx  = IDX_W'(req.position - 8'd1);
					cnt_d   = cnt_q - 1'b1;
				end
			end
			OP_READ_ALL: begin
				if (empty) begin
					ed_status = STAT_EMPTY;
				end else begin
					go_read = 1'b1;
				end
			end
			default: begin
			end
		endcase
		ed_val = (ed_kind == CK_DELETE) ? cell_q[ed_idx] : '0;
	end

	// command broadcast to the cell row
	always_comb begin
		cmd.kind = CK_HOLD;
		cmd.idx  = PL_IDX_W'(ed_idx);
		cmd.tail = PL_IDX_W'(cnt_q - 1'b1);
		if (fsm_q == FSM_READ) begin
			if (out_free) begin
				cmd.kind = CK_ROTATE;
			end
		end else if (acc) begin
			cmd.kind = ed_kind;
		end
	end

	// row of cells, each wired to its two neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_w[i] = '0;
		end else begin : g_inner_l
			assign left_w[i] = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_final
			assign right_w[i] = '0;
		end else begin : g_inner_r
			assign right_w[i] = cell_q[i+1];
		end
		plist_cell #(
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.load  (req.value),
			.left  (left_w[i]),
			.right (right_w[i]),
			.wrap  (cell_q[0]),
			.q     (cell_q[i])
		);
	end

	// control, count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= FSM_IDLE;
			cnt_q       <= '0;
			rd_left_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (fsm_q)
				FSM_IDLE: begin
					if (acc) begin
						cnt_q <= cnt_d;
						if (go_read) begin
							fsm_q     <= FSM_READ;
							rd_left_q <= cnt_q;
						end
					end
				end
				FSM_READ: begin
					if (out_free) begin
						rd_left_q <= rd_left_q - 1'b1;
						if (rd_left_q == CNT_W'(1)) begin
							fsm_q <= FSM_IDLE;
						end
					end
				end
				default: begin
					fsm_q <= FSM_IDLE;
				end
			endcase
			if ((acc && !go_read) || (fsm_q == FSM_READ && out_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (fsm_q == FSM_READ && out_free) begin
			rsp_q.result_value <= cell_q[0];
			rsp_q.status       <= STAT_OK;
			rsp_q.last         <= (rd_left_q == CNT_W'(1));
			rsp_q.length       <= 5'(cnt_q);
		end else if (acc && !go_read) begin
			rsp_q.result_value <= ed_val;
			rsp_q.status       <= ed_status;
			rsp_q.last         <= 1'b1;
			rsp_q.length       <= 5'(cnt_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// length never exceeds the row
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	// no request is taken during a read-out
	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == FSM_READ |-> !req_ready)
		else $error("request accepted during read-out");

	// a read-out always has words left to send
	a_read_left: assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == FSM_READ |-> rd_left_q != '0)
		else $error("read-out with nothing left");

	// the reported length tracks the held count
	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.length == 5'(cnt_q))
		else $error("response length differs from count");

endmodule

FILE: src/plist_cell.sv
// one storage cell of the list row, takes from its neighbors on edits
module plist_cell import plist_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  cell_cmd_t          cmd,
	input  logic signed [31:0] load,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	input  logic signed [31:0] wrap,
	output logic signed [31:0] q
);

	localparam logic [PL_IDX_W-1:0] MY_IDX = PL_IDX_W'(INDEX);

	logic signed [31:0] elem_q;

	// shift right of the edit point on insert, left on delete, ring on read-out
	always_ff @(posedge clk) begin
		case (cmd.kind)
			CK_INSERT: begin
				if (MY_IDX > cmd.idx) begin
					elem_q <= left;
				end else if (MY_IDX == cmd.idx) begin
					elem_q <= load;
				end
			end
			CK_DELETE: begin
				if (MY_IDX >= cmd.idx) begin
					elem_q <= right;
				end
			end
			CK_ROTATE: begin
				if (MY_IDX == cmd.tail) begin
					elem_q <= wrap;
				end else begin
					elem_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign q = elem_q;

endmodule

FILE: tb/sv/plist_checker.sv
// list checker: watches both channels, predicts every response word and compares
`timescale 1ns / 1ps

module plist_checker import plist_pkg::*; #(
	parameter int DEPTH = PL_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rsp_word_t rsp,
	output int        fail_count,
	output int        pending
);

	localparam int REPORT_MAX = 10;

	// predicted list contents, head first
	logic signed [31:0] list_cells [DEPTH];
	int                 list_len = 0;
	rsp_word_t          expected_rsp [$];
	int                 mismatches = 0;

	// one edit or read-out on the predicted list, queueing the words it answers with
	task automatic apply_request(input req_word_t w);
		status_t            st;
		logic signed [31:0] taken;
		rsp_word_t          word;
		int                 idx;
		int                 i;
		bit                 do_ins;
		bit                 do_del;
		st     = STAT_OK;
		taken  = '0;
		idx    = 0;
		do_ins = 1'b0;
		do_del = 1'b0;
		case (w.op)
			OP_INS_HEAD, OP_INS_TAIL: begin
				if (list_len >= DEPTH) begin
					st = STAT_FULL;
				end else begin
					do_ins = 1'b1;
					idx    = (w.op == OP_INS_HEAD) ? 0 : list_len;
				end
			end
			// zero-position check comes before the full check, the bounds check after it
			OP_INS_POS: begin
				if (w.position == 0) begin
					st = STAT_INVALID;
				end else if (list_len >= DEPTH) begin
					st = STAT_FULL;
				end else if (int'(w.position) > list_len + 1) begin
					st = STAT_BOUNDS;
				end else begin
					do_ins = 1'b1;
					idx    = int'(w.position) - 1;
				end
			end
			OP_DEL_HEAD, OP_DEL_TAIL: begin
				if (list_len == 0) begin
					st = STAT_EMPTY;
				end else begin
					do_del = 1'b1;
					idx    = (w.op == OP_DEL_HEAD) ? 0 : list_len - 1;
				end
			end
			OP_DEL_POS: begin
				if (w.position == 0 || list_len == 0) begin
					st = STAT_INVALID;
				end else if (int'(w.position) > list_len) begin
					st = STAT_BOUNDS;
				end else begin
					do_del = 1'b1;
					idx    = int'(w.position) - 1;
				end
			end
			default: begin
			end
		endcase

		if (do_ins) begin
			for (i = list_len; i > idx; i--)
				list_cells[i] = list_cells[i-1];
			list_cells[idx] = w.value;
			list_len++;
		end
		if (do_del) begin
			taken = list_cells[idx];
			for (i = idx; i < list_len - 1; i++)
				list_cells[i] = list_cells[i+1];
			list_len--;
		end

		if (w.op == OP_READ_ALL && list_len > 0) begin
			// one word per element, head to tail
			for (i = 0; i < list_len; i++) begin
				word.result_value = list_cells[i];
				word.status       = STAT_OK;
				word.last         = (i == list_len - 1);
				word.length       = 5'(list_len);
				expected_rsp.push_back(word);
			end
		end else begin
			word.result_value = taken;
			word.status       = (w.op == OP_READ_ALL) ? STAT_EMPTY : st;
			word.last         = 1'b1;
			word.length       = 5'(list_len);
			expected_rsp.push_back(word);
		end
	endtask

	// compare a taken response word with the oldest prediction
	task automatic check_word(input rsp_word_t got);
		rsp_word_t want;
		if (expected_rsp.size() == 0) begin
			if (mismatches < REPORT_MAX)
				$display("checker: unexpected word value=%0d status=%0d last=%0b length=%0d",
					got.result_value, got.status, got.last, got.length);
			mismatches++;
		end else begin
			want = expected_rsp.pop_front();
			if (got.result_value !== want.result_value || got.status !== want.status ||
			    got.last !== want.last || got.length !== want.length) begin
				if (mismatches < REPORT_MAX)
					$display("checker: mismatch expected value=%0d status=%0d last=%0b length=%0d, got value=%0d status=%0d last=%0b length=%0d",
						want.result_value, want.status, want.last, want.length,
						got.result_value, got.status, got.last, got.length);
				mismatches++;
			end
		end
	endtask

	// response first, so a word taken in the accept cycle of a request
	// is matched against older predictions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_rsp.delete();
			pending    <= 0;
			fail_count <= mismatches;
		end else begin
			if (rsp_valid && rsp_ready)
				check_word(rsp);
			if (req_valid && req_ready)
				apply_request(req);
			pending    <= expected_rsp.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// testbench top: clock, reset, request stimulus, response back-pressure and verdict
`timescale 1ns / 1ps

module testbench;
	import plist_pkg::*;

	localparam int         DEPTH        = PL_DEPTH_DEF;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_CYCLES = 20;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         PHASE_ITEMS  = 77;
	localparam logic [2:0] OP_RESERVED  = 3'd7;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	int   fail_count;
	int   pending;
	int   send_idle_pct = 13;
	int   recv_idle_pct = 57;
	int   hold_left     = 0;
	int   cycle_count   = 0;
	logic stall_req     = 1'b0;

	always #2 clk = ~clk;

	positional_list_engine #(.DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	plist_checker #(.DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver: random stalls, or a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (stall_req) begin
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: errors");
		$finish;
	end

	function automatic req_word_t make_word(input op_t op, input logic [31:0] v,
		input logic [7:0] p);
		req_word_t w;
		w.op       = op;
		w.value    = v;
		w.position = p;
		return w;
	endfunction

	// random request word; grow favors inserts, otherwise deletes dominate
	function automatic req_word_t rand_word(input bit grow);
		op_t         ins_ops [3];
		op_t         del_ops [3];
		op_t         op;
		logic [31:0] v;
		logic [7:0]  p;
		int          k;
		int          ins_share;
		ins_ops   = '{OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS};
		del_ops   = '{OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS};
		ins_share = grow ? 62 : 28;
		k         = $urandom_range(99);
		if (k < 2)
			op = op_t'(OP_RESERVED);
		else if (k < 10)
			op = OP_READ_ALL;
		else if (k < 10 + ins_share)
			op = ins_ops[$urandom_range(2)];
		else
			op = del_ops[$urandom_range(2)];
		case ($urandom_range(9))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = 32'h0000_0000;
			default: v = $urandom();
		endcase
		if ($urandom_range(7) == 0)
			p = 8'($urandom_range(255));
		else
			p = 8'($urandom_range(DEPTH + 2));
		return make_word(op, v, p);
	endfunction

	// offer one word after a random gap and hold it until it is taken
	task automatic send_word(input req_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!req_ready);
	endtask

	// stop offering and wait until every predicted word has been taken
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int i;
		int n;
		int phase;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty list corner cases
		send_word(make_word(OP_READ_ALL, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_HEAD, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_TAIL, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'd1));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'd0));
		send_word(make_word(OP_INS_POS, 32'h1234_5678, 8'd0));
		send_word(make_word(OP_INS_POS, 32'h1234_5678, 8'd2));
		send_word(make_word(op_t'(OP_RESERVED), 32'hFFFF_FFFF, 8'hFF));

		// edits at every place, value extremes, out of range positions
		send_word(make_word(OP_INS_HEAD, 32'h7FFF_FFFF, 8'd0));
		send_word(make_word(OP_INS_TAIL, 32'h8000_0000, 8'd0));
		send_word(make_word(OP_INS_POS, 32'hFFFF_FFFF, 8'd2));
		send_word(make_word(OP_INS_POS, 32'h5555_5555, 8'd4));
		send_word(make_word(OP_INS_POS, 32'hAAAA_AAAA, 8'd6));
		send_word(make_word(OP_INS_POS, 32'h0000_0001, 8'hFF));
		send_word(make_word(OP_READ_ALL, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'd5));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'hFF));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'd2));
		send_word(make_word(OP_DEL_HEAD, 32'h0, 8'd0));
		send_word(make_word(op_t'(OP_RESERVED), 32'h0, 8'd0));
		send_word(make_word(OP_DEL_TAIL, 32'h0, 8'd0));
		send_word(make_word(OP_READ_ALL, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'd1));

		// long receiver hold-off while the list is filled past full
		req_valid <= 1'b0;
		stall_req <= 1'b1;
		@(posedge clk);
		stall_req <= 1'b0;
		for (i = 0; i < DEPTH + 2; i++)
			send_word(make_word(OP_INS_TAIL, $urandom(), 8'd0));
		send_word(make_word(OP_INS_POS, $urandom(), 8'd0));
		send_word(make_word(OP_INS_POS, $urandom(), 8'd1));
		send_word(make_word(OP_INS_HEAD, $urandom(), 8'd0));
		send_word(make_word(OP_READ_ALL, 32'h0, 8'd0));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'(DEPTH)));
		send_word(make_word(OP_DEL_POS, 32'h0, 8'(DEPTH)));
		send_word(make_word(OP_INS_POS, $urandom(), 8'(DEPTH)));
		send_word(make_word(OP_READ_ALL, 32'h0, 8'd0));

		// random traffic under three idling mixes
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 57;
				end
				1: begin
					wait_drained();
					send_idle_pct = 57;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				send_word(rand_word(((n / 20) % 2) == 0));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/plist_pkg.sv
src/plist_cell.sv
src/positional_list_engine.sv
tb/sv/plist_checker.sv
tb/sv/testbench.sv
